// ===== rtl/core/aes_pkg.sv =====
// Package for the AES-128 encryption pipeline: types, S-box table and round helpers.
// Depends on nothing; aes_round_cell.sv and aes128_block_encrypt_unit.sv import it.
`default_nettype none
package aes_pkg;

	localparam int RoundCount  = 10;
	localparam int KeyWidth    = 128;
	localparam int HalfWidth   = 64;
	localparam int CntWidth    = 5;
	localparam int CfgIdxWidth = 2;

	localparam logic [CfgIdxWidth-1:0] CfgKeyUpper = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CfgKeyLower = 2'd1;

	typedef logic [KeyWidth-1:0] block_t;

	typedef struct packed {
		logic   valid;
		block_t state;
		block_t rkey;
	} stage_t;

	localparam logic [7:0] SboxTab [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RconTab [RoundCount] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits at bits [127-8i -: 8].
	function automatic logic [7:0] get_byte(input block_t b, input int i);
		get_byte = b[KeyWidth-1-8*i -: 8];
	endfunction

	// One key-expansion step: round key r-1 to round key r.
	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {SboxTab[k[23:16]], SboxTab[k[15:8]], SboxTab[k[7:0]], SboxTab[k[31:24]]};
		t[31:24] = t[31:24] ^ rc;
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

	// SubBytes and ShiftRows, then MixColumns when mix is set.
	function automatic block_t round_fn(input block_t s, input logic mix);
		block_t t;
		block_t m;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[KeyWidth-1-8*(c*4+r) -: 8] = SboxTab[get_byte(s, ((c + r) % 4) * 4 + r)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(t, c*4);
			a1 = get_byte(t, c*4+1);
			a2 = get_byte(t, c*4+2);
			a3 = get_byte(t, c*4+3);
			m[KeyWidth-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			m[KeyWidth-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			m[KeyWidth-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			m[KeyWidth-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		round_fn = mix ? m : t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/aes_if.sv =====
// Valid/ready stream interface used for the block, result and key-write channels.
// Depends on nothing; payload width is given when instantiated.
`default_nettype none
interface aes_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aes_round_cell.sv =====
// One pipeline cell: one AES round on the state and one key-expansion step beside it.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell
	import aes_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] rcon,
	input  wire logic       mix,
	input  wire stage_t     prev,
	output stage_t          cur
);
	block_t nk;
	logic   valid_q;
	block_t state_q;
	block_t rkey_q;

	assign nk = next_key(prev.rkey, rcon);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= round_fn(prev.state, mix) ^ nk;
			rkey_q  <= nk;
		end
	end

	assign cur = '{valid: valid_q, state: state_q, rkey: rkey_q};
endmodule
`default_nettype wire

// ===== rtl/core/aes128_block_encrypt_unit.sv =====
// Top level of the AES-128 ECB encryption pipeline.
// Depends on aes_pkg, aes_stream_if and aes_round_cell.
`default_nettype none
// The unit accepts one 128-bit plaintext beat per clock while the row advances and
// presents its ciphertext from the last cell: padding and the initial AddRoundKey are
// registered at the accepting edge, then one cell per round in a row of ten round cells, each
// carrying its block together with that block's round key. Every cell expands its own
// round key from the one handed to it, so no key schedule is stored. A short block
// (valid_bytes below 16) is padded with 0x80 after the last valid byte and zeros after
// that. The row advances whenever the last cell is empty or its result is being taken,
// so a stalled output holds the whole row and throughput is one block per cycle while
// the output sink keeps up. The key registers (index 0 for bytes 0..7, index 1 for
// bytes 8..15) may only be written while no block is in flight; other indices are
// ignored.
module aes128_block_encrypt_unit
	import aes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	aes_stream_if.sink   cfg,
	aes_stream_if.sink   plain,
	aes_stream_if.source cipher
);
	// cfg.data: {index[1:0], value[63:0]}; plain.data: {upper, lower, valid_bytes};
	// cipher.data: {upper, lower}.
	logic [HalfWidth-1:0]   key_upper_q, key_lower_q;
	logic [CfgIdxWidth-1:0] cfg_idx;
	logic                   adv;
	stage_t                 row [RoundCount+1];
	logic                   s0_valid_q;
	block_t                 s0_state_q;
	block_t                 s0_rkey_q;
	block_t                 padded;
	logic [CntWidth-1:0]    nbytes;

	assign cfg.ready = 1'b1;
	assign cfg_idx   = cfg.data[HalfWidth+CfgIdxWidth-1:HalfWidth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg_idx == CfgKeyUpper) begin
				key_upper_q <= cfg.data[HalfWidth-1:0];
			end else if (cfg_idx == CfgKeyLower) begin
				key_lower_q <= cfg.data[HalfWidth-1:0];
			end
		end
	end

	// The row moves when the final cell is empty or being drained.
	assign adv         = !row[RoundCount].valid || cipher.ready;
	assign plain.ready = adv;

	// Padding: when the count is below 16, bytes at and past it are replaced.
	assign nbytes = plain.data[CntWidth-1:0];
	always_comb begin
		padded = plain.data[2*HalfWidth+CntWidth-1:CntWidth];
		for (int i = 0; i < 16; i++) begin
			if (nbytes < CntWidth'(16)) begin
				if (CntWidth'(i) == nbytes) begin
					padded[KeyWidth-1-8*i -: 8] = 8'h80;
				end else if (CntWidth'(i) > nbytes) begin
					padded[KeyWidth-1-8*i -: 8] = 8'h00;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
		end else if (adv) begin
			s0_valid_q <= plain.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s0_state_q <= padded ^ {key_upper_q, key_lower_q};
			s0_rkey_q  <= {key_upper_q, key_lower_q};
		end
	end

	assign row[0] = '{valid: s0_valid_q, state: s0_state_q, rkey: s0_rkey_q};

	for (genvar g = 0; g < RoundCount; g++) begin : g_cell
		aes_round_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.rcon   (RconTab[g]),
			.mix    (g != RoundCount - 1),
			.prev   (row[g]),
			.cur    (row[g+1])
		);
	end

	assign cipher.valid = row[RoundCount].valid;
	assign cipher.data  = row[RoundCount].state;
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the AES-128 ECB encryption unit.
// Depends on aes_pkg and aes_stream_if; every check comes from an independent cipher model.
`timescale 1ns / 100ps
module tb;
	import aes_pkg::*;

	localparam int PlainW  = 2 * HalfWidth + CntWidth;
	localparam int CfgW    = CfgIdxWidth + HalfWidth;
	localparam int PipeLat = 16;
	localparam int Limit   = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aes_stream_if #(.W(CfgW))     cfg ();
	aes_stream_if #(.W(PlainW))   plain ();
	aes_stream_if #(.W(KeyWidth)) cipher ();

	aes128_block_encrypt_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .plain(plain), .cipher(cipher)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The model's own copy of the key and its own S-box, built from the field inverse.
	logic [63:0] key_hi, key_lo;
	logic [7:0] sub_lut [256];
	logic [127:0] cipher_q [$];
	int errors;
	int cycles;
	int hold_cycles;
	int out_stall;
	bit idle_rand;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) acc ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic logic [7:0] calc_sub(input logic [7:0] x);
		logic [7:0] inv, sq, r;
		inv = 8'h01;
		sq = x;
		for (int e = 254; e != 0; e = e >> 1) begin
			if (e & 1) inv = gmul(inv, sq);
			sq = gmul(sq, sq);
		end
		if (x == 8'h00) inv = 8'h00;
		r = 8'h63 ^ inv;
		for (int k = 1; k < 5; k++) r ^= (inv << k) | (inv >> (8 - k));
		return r;
	endfunction

	// Pads, expands the key and runs all ten rounds; byte 0 sits in the top bits.
	function automatic logic [127:0] encrypt_block(input logic [63:0] up, input logic [63:0] lo,
			input logic [4:0] count);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [31:0] w [44];
		logic [31:0] tmp;
		logic [7:0] rc, a0, a1, a2, a3;
		logic [127:0] blk, res;
		blk = {up, lo};
		for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
		if (count < 16) begin
			s[count] = 8'h80;
			for (int i = count + 1; i < 16; i++) s[i] = 8'h00;
		end
		w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
		w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			tmp = w[i-1];
			if (i % 4 == 0) begin
				tmp = {tmp[23:0], tmp[31:24]};
				tmp = {sub_lut[tmp[31:24]], sub_lut[tmp[23:16]], sub_lut[tmp[15:8]],
					sub_lut[tmp[7:0]]} ^ {rc, 24'h0};
				rc = gmul(rc, 8'h02);
			end
			w[i] = w[i-4] ^ tmp;
		end
		for (int rnd = 0; rnd <= RoundCount; rnd++) begin
			if (rnd > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) t[c*4+r] = sub_lut[s[((c + r) % 4) * 4 + r]];
				s = t;
				if (rnd < RoundCount) begin
					for (int c = 0; c < 4; c++) begin
						a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
						s[c*4]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
						s[c*4+1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
						s[c*4+2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
						s[c*4+3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) s[c*4+r] ^= w[rnd*4+c][31-8*r -: 8];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Output side: random stalls per beat, plus long hold-offs when asked.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			cipher.ready <= 1'b0;
			hold_cycles--;
		end else if (out_stall > 0) begin
			cipher.ready <= 1'b0;
			out_stall--;
		end else begin
			cipher.ready <= 1'b1;
		end
	end

	// Compares every ciphertext beat with the oldest pending block, half by half.
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && cipher.valid && cipher.ready) begin
			if (cipher_q.size() == 0) begin
				report("unexpected beat", cipher.data, '0);
			end else begin
				want = cipher_q.pop_front();
				if (cipher.data[127:64] !== want[127:64])
					report("cipher_upper", cipher.data, want);
				if (cipher.data[63:0] !== want[63:0])
					report("cipher_lower", cipher.data, want);
			end
			out_stall = idle_rand ? $urandom_range(0, 3) : 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > Limit) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic send_block(input logic [63:0] up, input logic [63:0] lo, input logic [4:0] n);
		int gap;
		gap = idle_rand ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			plain.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		plain.valid <= 1'b1;
		plain.data <= {up, lo, n};
		do @(posedge clk); while (!plain.ready);
		cipher_q.push_back(encrypt_block(up, lo, n));
		@(negedge clk);
	endtask

	// Lets every block drain and keeps the input idle before the key moves.
	task automatic drain();
		plain.valid <= 1'b0;
		wait (cipher_q.size() == 0);
		repeat (PipeLat) @(negedge clk);
	endtask

	task automatic write_key(input logic [CfgIdxWidth-1:0] idx, input logic [63:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= {idx, value};
		do @(posedge clk); while (!cfg.ready);
		if (idx == CfgKeyUpper) key_hi = value; else key_lo = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Blocks under the reset key of all zeros, including all-zero and all-one data.
	task automatic test_reset_key();
		send_block('0, '0, 5'd16);
		send_block('1, '1, 5'd16);
		send_block(rand64(), rand64(), 5'd16);
	endtask

	// The standard published vector, then each padding length from empty to overlong.
	task automatic test_padding();
		write_key(CfgKeyUpper, 64'h0001020304050607);
		write_key(CfgKeyLower, 64'h08090a0b0c0d0e0f);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16);
		for (int n = 0; n < 16; n++) send_block('1, '1, n[4:0]);
		send_block(rand64(), rand64(), 5'd17);
		send_block(rand64(), rand64(), 5'd31);
		send_block('0, '0, 5'd0);
	endtask

	// Key extremes: all ones in both halves, then mixed halves.
	task automatic test_key_extremes();
		write_key(CfgKeyUpper, '1);
		write_key(CfgKeyLower, '1);
		send_block('0, '0, 5'd16);
		send_block('1, '1, 5'd7);
		write_key(CfgKeyLower, '0);
		send_block(rand64(), rand64(), 5'd16);
	endtask

	// Holds the output off long enough for the row to fill and push back on the input.
	task automatic test_backpressure();
		hold_cycles = 80;
		for (int i = 0; i < 40; i++) send_block(rand64(), rand64(), 5'd16);
		drain();
	endtask

	task automatic test_random(input int count);
		logic [4:0] n;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 149) begin
				write_key(i[0] ? CfgKeyUpper : CfgKeyLower, rand64());
				idle_rand = ($urandom_range(0, 3) != 0);
			end
			if (i == count / 2) drain();
			n = ($urandom_range(0, 9) < 6) ? 5'd16 : 5'($urandom_range(0, 31));
			send_block(rand64(), rand64(), n);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		out_stall = 0;
		idle_rand = 1'b1;
		key_hi = '0;
		key_lo = '0;
		for (int i = 0; i < 256; i++) sub_lut[i] = calc_sub(i[7:0]);
		cfg.valid = 1'b0;
		cfg.data = '0;
		plain.valid = 1'b0;
		plain.data = '0;
		cipher.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_key();
		test_padding();
		test_key_extremes();
		write_key(CfgKeyUpper, rand64());
		write_key(CfgKeyLower, rand64());
		test_backpressure();
		test_random(860);
		drain();
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
